>>> rtl/core/priority_weighted_round_robin_picker_defines.svh
// assertion macros for the priority weighted round robin picker
`ifndef PRIORITY_WEIGHTED_ROUND_ROBIN_PICKER_DEFINES_SVH
`define PRIORITY_WEIGHTED_ROUND_ROBIN_PICKER_DEFINES_SVH

// clocked assertion, off while reset is high
`define PWRR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pwrr: check failed");

// same, on the block's own clock and reset
`define PWRR_CHECK(label, prop) `PWRR_ASSERT(label, clock, reset, prop)

`endif

>>> rtl/core/pwrr_pkg.sv
// shared types and constants of the priority weighted round robin picker
`default_nettype none

package pwrr_pkg;

   localparam int FIELD_W = 16;
   localparam int SLOT_W  = 4;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_PICK  = 1'b1;

   typedef struct packed {
      logic               command;
      logic [SLOT_W-1:0]  entry_slot;
      logic [FIELD_W-1:0] new_priority;
      logic [FIELD_W-1:0] new_weight;
      logic               new_valid;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] granted_slot;
   } rsp_type;

   typedef struct packed {
      logic lt;
      logic eq;
   } cmp_type;

endpackage

`default_nettype wire

>>> rtl/core/pwrr_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module pwrr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/pwrr_unit.sv
// shared compare and add unit used by every pass of the picker
`default_nettype none

module pwrr_unit #(
   parameter int WIDTH = 20
) (
   input  wire logic [WIDTH-1:0] lhs,
   input  wire logic [WIDTH-1:0] rhs,
   input  wire logic [WIDTH-1:0] acc,
   input  wire logic [WIDTH-1:0] addend,
   output pwrr_pkg::cmp_type     cmp,
   output logic      [WIDTH-1:0] sum
);

   assign cmp.lt = (lhs < rhs);
   assign cmp.eq = (lhs == rhs);
   assign sum    = acc + addend;

endmodule

`default_nettype wire

>>> rtl/core/priority_weighted_round_robin_picker.sv
// top level: priority weighted round robin picker over an entry table in ram
// a write word is done in the cycle it is taken; a pick reads the table ram one entry per
// cycle in its min and group sum passes, with one shared compare unit; the min pass always
// runs, the group sum pass only on a table with a present entry, the weight fix pass and
// second scan round only when needed; next word taken while the result word is first shown
// reset (synchronous) clears valid marks, use counts and cursor at once, no clearing pass
`default_nettype none

module priority_weighted_round_robin_picker #(
   parameter int ENTRIES = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire pwrr_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output pwrr_pkg::rsp_type      rsp_data
);

   localparam int FW       = pwrr_pkg::FIELD_W;
   localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W    = $clog2(ENTRIES + 1);
   localparam int ACC_W    = FW + IDX_W;
   localparam int ENTRY_W  = 2 * FW;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
   localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRIES);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIN,
      ST_SUM,
      ST_FIX,
      ST_SCAN,
      ST_WAIT,
      ST_RESULT
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  pidx_ff, pidx_in;
   logic [FW-1:0]     best_ff, best_in;
   logic              any_ff, any_in;
   logic [ACC_W-1:0]  total_ff, total_in;
   logic [ACC_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  steps_ff, steps_in;
   logic              round2_ff, round2_in;
   logic [IDX_W-1:0]  cursor_ff, cursor_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [ENTRIES-1:0] live_ff, live_in;
   logic [ENTRIES-1:0] member_ff, member_in;
   pwrr_pkg::rsp_type res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   pwrr_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // table ram: priority in the upper half, weight in the lower half
   logic               pw_wr_en;
   logic [IDX_W-1:0]   pw_wr_addr;
   logic [ENTRY_W-1:0] pw_wr_data;
   logic               pw_rd_en;
   logic [IDX_W-1:0]   pw_rd_addr;
   logic [ENTRY_W-1:0] pw_rd_data;
   logic               uses_wr_en;
   logic [FW-1:0]      uses_wr_data;
   logic               uses_rd_en;
   logic [FW-1:0]      uses_rd_data;

   logic [FW-1:0]     rd_prio;
   logic [FW-1:0]     rd_weight;
   logic [FW-1:0]     uses_eff;
   logic [IDX_W-1:0]  slot_idx;
   logic              slot_in_range;
   logic [IDX_W-1:0]  cursor_next;

   logic [ACC_W-1:0]  u_lhs, u_rhs, u_acc, u_addend, u_sum;
   pwrr_pkg::cmp_type u_cmp;

   assign rd_prio       = pw_rd_data[ENTRY_W-1:FW];
   assign rd_weight     = pw_rd_data[FW-1:0];
   assign uses_eff      = live_ff[cursor_ff] ? uses_rd_data : '0;
   assign slot_idx      = IDX_W'(req_data.entry_slot);
   assign slot_in_range = (32'(req_data.entry_slot) < ENTRIES);
   assign cursor_next   = (cursor_ff == LAST_IDX) ? '0 : cursor_ff + 1'b1;

   pwrr_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(ENTRIES)
   ) u_table_ram (
      .clock  (clock),
      .wr_en  (pw_wr_en),
      .wr_addr(pw_wr_addr),
      .wr_data(pw_wr_data),
      .rd_en  (pw_rd_en),
      .rd_addr(pw_rd_addr),
      .rd_data(pw_rd_data)
   );

   pwrr_ram #(
      .WIDTH(FW),
      .DEPTH(ENTRIES)
   ) u_uses_ram (
      .clock  (clock),
      .wr_en  (uses_wr_en),
      .wr_addr(cursor_ff),
      .wr_data(uses_wr_data),
      .rd_en  (uses_rd_en),
      .rd_addr(pw_rd_addr),
      .rd_data(uses_rd_data)
   );

   pwrr_unit #(
      .WIDTH(ACC_W)
   ) u_unit (
      .lhs   (u_lhs),
      .rhs   (u_rhs),
      .acc   (u_acc),
      .addend(u_addend),
      .cmp   (u_cmp),
      .sum   (u_sum)
   );

   // operand selection for the shared unit
   always_comb begin
      u_lhs    = '0;
      u_rhs    = '0;
      u_acc    = total_ff;
      u_addend = '0;
      case (state_ff)
         ST_MIN, ST_SUM: begin
            u_lhs    = ACC_W'(rd_prio);
            u_rhs    = ACC_W'(best_ff);
            u_addend = ACC_W'(rd_weight);
         end
         ST_FIX: begin
            u_addend = ACC_W'(1'b1);
         end
         ST_SCAN: begin
            u_lhs = sum_ff;
            u_rhs = total_ff;
         end
         ST_WAIT: begin
            u_lhs    = ACC_W'(uses_eff);
            u_rhs    = ACC_W'(rd_weight);
            u_acc    = sum_ff;
            u_addend = ACC_W'(uses_eff);
         end
         default: begin
            u_acc = total_ff;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pidx_in      = pidx_ff;
      best_in      = best_ff;
      any_in       = any_ff;
      total_in     = total_ff;
      sum_in       = sum_ff;
      steps_in     = steps_ff;
      round2_in    = round2_ff;
      cursor_in    = cursor_ff;
      valid_in     = valid_ff;
      live_in      = live_ff;
      member_in    = member_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      pw_wr_en     = 1'b0;
      pw_wr_addr   = slot_idx;
      pw_wr_data   = {req_data.new_priority, req_data.new_weight};
      pw_rd_en     = 1'b0;
      pw_rd_addr   = idx_ff[IDX_W-1:0];
      uses_wr_en   = 1'b0;
      uses_wr_data = uses_eff + 1'b1;
      uses_rd_en   = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.command == pwrr_pkg::CMD_WRITE) begin
                  if (slot_in_range) begin
                     pw_wr_en           = 1'b1;
                     valid_in[slot_idx] = req_data.new_valid;
                     live_in[slot_idx]  = 1'b0;
                  end
               end else begin
                  idx_in   = '0;
                  pend_in  = 1'b0;
                  any_in   = 1'b0;
                  state_in = ST_MIN;
               end
            end
         end

         ST_MIN, ST_SUM: begin
            // one table read issued per cycle, data handled in the next cycle
            if (idx_ff < CNT_END) begin
               pw_rd_en = 1'b1;
               idx_in   = idx_ff + 1'b1;
               pend_in  = 1'b1;
               pidx_in  = idx_ff[IDX_W-1:0];
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if (state_ff == ST_MIN) begin
                  if (valid_ff[pidx_ff] && (!any_ff || u_cmp.lt)) begin
                     best_in = rd_prio;
                     any_in  = 1'b1;
                  end
               end else begin
                  member_in[pidx_ff] = valid_ff[pidx_ff] && u_cmp.eq;
                  if (valid_ff[pidx_ff] && u_cmp.eq) begin
                     total_in = u_sum;
                  end
               end
               if (pidx_ff == LAST_IDX) begin
                  idx_in  = '0;
                  pend_in = 1'b0;
                  if (state_ff == ST_MIN) begin
                     if (any_in) begin
                        total_in = '0;
                        state_in = ST_SUM;
                     end else begin
                        res_in   = '0;
                        state_in = ST_RESULT;
                     end
                  end else begin
                     sum_in    = '0;
                     steps_in  = '0;
                     round2_in = 1'b0;
                     state_in  = (total_in == '0) ? ST_FIX : ST_SCAN;
                  end
               end
            end
         end

         ST_FIX: begin
            // zero weight group: every member gets weight one
            if (member_ff[idx_ff[IDX_W-1:0]]) begin
               pw_wr_en   = 1'b1;
               pw_wr_addr = idx_ff[IDX_W-1:0];
               pw_wr_data = {best_ff, FW'(1)};
               total_in   = u_sum;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff[IDX_W-1:0] == LAST_IDX) begin
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (u_cmp.lt && (steps_ff < CNT_END)) begin
               steps_in  = steps_ff + 1'b1;
               cursor_in = cursor_next;
               if (member_ff[cursor_next]) begin
                  pw_rd_en   = 1'b1;
                  uses_rd_en = 1'b1;
                  pw_rd_addr = cursor_next;
                  state_in   = ST_WAIT;
               end
            end else if (!round2_ff) begin
               // round used up: clear all use counts and scan again
               live_in   = '0;
               round2_in = 1'b1;
               sum_in    = '0;
               steps_in  = '0;
            end else begin
               res_in   = '0;
               state_in = ST_RESULT;
            end
         end

         ST_WAIT: begin
            if (u_cmp.lt) begin
               uses_wr_en          = 1'b1;
               live_in[cursor_ff]  = 1'b1;
               res_in.found        = 1'b1;
               res_in.granted_slot = pwrr_pkg::SLOT_W'(cursor_ff);
               state_in            = ST_RESULT;
            end else begin
               sum_in   = u_sum;
               state_in = ST_SCAN;
            end
         end

         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         cursor_ff    <= '0;
         valid_ff     <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         cursor_ff    <= cursor_in;
         valid_ff     <= valid_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      pidx_ff     <= pidx_in;
      best_ff     <= best_in;
      any_ff      <= any_in;
      total_ff    <= total_in;
      sum_ff      <= sum_in;
      steps_ff    <= steps_in;
      round2_ff   <= round2_in;
      member_ff   <= member_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/pwrr_checker.sv
// port level checks of the picker, bound to the top level
`default_nettype none
`include "priority_weighted_round_robin_picker_defines.svh"

module pwrr_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire pwrr_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire pwrr_pkg::rsp_type rsp_data
);

   logic seen_valid_ff, seen_valid_in;

   // set once any entry has been written as present
   always_comb begin
      seen_valid_in = seen_valid_ff;
      if (req_valid && !req_stall && req_data.command == pwrr_pkg::CMD_WRITE
          && req_data.new_valid) begin
         seen_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_valid_ff <= 1'b0;
      end else begin
         seen_valid_ff <= seen_valid_in;
      end
   end

   `PWRR_CHECK(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
   `PWRR_CHECK(a_pick_busy, req_valid && !req_stall && req_data.command == pwrr_pkg::CMD_PICK |=> req_stall)
   `PWRR_CHECK(a_miss_slot, rsp_valid && !rsp_data.found |-> rsp_data.granted_slot == '0)
   `PWRR_CHECK(a_empty_table, rsp_valid && !seen_valid_ff |-> !rsp_data.found)

endmodule

bind priority_weighted_round_robin_picker pwrr_checker u_pwrr_checker (.*);

`default_nettype wire

>>> bench/tb.sv
// testbench for the priority weighted round robin picker: random words checked against a table model
module tb;

   localparam int ENTRIES = 16;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 150;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   pwrr_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   pwrr_pkg::rsp_type rsp_data;

   pwrr_pkg::req_type pending_words[$];
   pwrr_pkg::rsp_type grants_due[$];

   int sender_idle_pct = 0;
   int rcv_idle_pct = 0;
   int holds_asked = 0;
   int holds_served = 0;
   int hold_left = 0;
   int errors = 0;

   logic              word_taken = 1'b0;
   pwrr_pkg::req_type taken_word = '0;
   pwrr_pkg::rsp_type want;

   // table model
   logic                         tbl_valid [ENTRIES];
   logic [pwrr_pkg::FIELD_W-1:0] tbl_prio [ENTRIES];
   logic [pwrr_pkg::FIELD_W-1:0] tbl_weight [ENTRIES];
   logic [pwrr_pkg::FIELD_W-1:0] tbl_uses [ENTRIES];
   logic [pwrr_pkg::SLOT_W-1:0]  scan_pos;

   priority_weighted_round_robin_picker #(.ENTRIES(ENTRIES)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   initial begin
      for (int i = 0; i < ENTRIES; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_prio[i] = '0;
         tbl_weight[i] = '0;
         tbl_uses[i] = '0;
      end
      scan_pos = '0;
   end

   // one round of the cursor over the table, returns granted slot or -1
   function automatic int scan_once(logic [pwrr_pkg::FIELD_W-1:0] best, int unsigned total);
      int unsigned used_sum;
      used_sum = 0;
      for (int steps = 0; steps < ENTRIES && used_sum < total; steps++) begin
         scan_pos = scan_pos + 1'b1;
         if (tbl_valid[scan_pos] && tbl_prio[scan_pos] == best) begin
            if (tbl_uses[scan_pos] < tbl_weight[scan_pos]) begin
               tbl_uses[scan_pos] = tbl_uses[scan_pos] + 1'b1;
               return int'(scan_pos);
            end
            used_sum += tbl_uses[scan_pos];
         end
      end
      return -1;
   endfunction

   function automatic void apply_word(pwrr_pkg::req_type w);
      pwrr_pkg::rsp_type            r;
      logic                         have;
      logic [pwrr_pkg::FIELD_W-1:0] best;
      int unsigned                  total;
      int                           slot;
      r = '0;
      have = 1'b0;
      best = '0;
      total = 0;
      if (w.command == pwrr_pkg::CMD_WRITE) begin
         if (int'(w.entry_slot) < ENTRIES) begin
            tbl_prio[w.entry_slot] = w.new_priority;
            tbl_weight[w.entry_slot] = w.new_weight;
            tbl_valid[w.entry_slot] = w.new_valid;
            tbl_uses[w.entry_slot] = '0;
         end
         return;
      end
      for (int i = 0; i < ENTRIES; i++) begin
         if (tbl_valid[i] && (!have || tbl_prio[i] < best)) begin
            best = tbl_prio[i];
            have = 1'b1;
         end
      end
      if (!have) begin
         grants_due = {grants_due, r};
         return;
      end
      for (int i = 0; i < ENTRIES; i++)
         if (tbl_valid[i] && tbl_prio[i] == best) total += tbl_weight[i];
      // all-zero group gets weight one each
      if (total == 0) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_prio[i] == best) begin
               tbl_weight[i] = 1;
               total++;
            end
         end
      end
      slot = scan_once(best, total);
      if (slot < 0) begin
         // round used up: clear every count and scan on from the cursor
         for (int i = 0; i < ENTRIES; i++) tbl_uses[i] = '0;
         slot = scan_once(best, total);
      end
      if (slot >= 0) begin
         r.found = 1'b1;
         r.granted_slot = slot[pwrr_pkg::SLOT_W-1:0];
      end
      grants_due = {grants_due, r};
   endfunction

   function automatic pwrr_pkg::req_type table_write(int slot, int prio, int weight,
                                                     bit present);
      pwrr_pkg::req_type w;
      w.command = pwrr_pkg::CMD_WRITE;
      w.entry_slot = slot[pwrr_pkg::SLOT_W-1:0];
      w.new_priority = prio[pwrr_pkg::FIELD_W-1:0];
      w.new_weight = weight[pwrr_pkg::FIELD_W-1:0];
      w.new_valid = present;
      return w;
   endfunction

   function automatic pwrr_pkg::req_type pick_word();
      pwrr_pkg::req_type w;
      w.command = pwrr_pkg::CMD_PICK;
      w.entry_slot = pwrr_pkg::SLOT_W'($urandom_range(15));
      w.new_priority = pwrr_pkg::FIELD_W'($urandom_range(65535));
      w.new_weight = pwrr_pkg::FIELD_W'($urandom_range(65535));
      w.new_valid = 1'($urandom_range(1));
      return w;
   endfunction

   // small priority and weight ranges so groups form and rounds run out
   function automatic pwrr_pkg::req_type random_word();
      pwrr_pkg::req_type w;
      int                roll;
      w.command = ($urandom_range(99) < 45) ? pwrr_pkg::CMD_PICK : pwrr_pkg::CMD_WRITE;
      w.entry_slot = pwrr_pkg::SLOT_W'($urandom_range(15));
      roll = $urandom_range(99);
      if (roll < 85) w.new_priority = pwrr_pkg::FIELD_W'($urandom_range(3));
      else w.new_priority = pwrr_pkg::FIELD_W'($urandom_range(65535));
      roll = $urandom_range(99);
      if (roll < 70) w.new_weight = pwrr_pkg::FIELD_W'($urandom_range(1, 3));
      else if (roll < 85) w.new_weight = '0;
      else w.new_weight = pwrr_pkg::FIELD_W'($urandom_range(65535));
      w.new_valid = ($urandom_range(99) < 80);
      return w;
   endfunction

   task automatic queue_word(pwrr_pkg::req_type w);
      pending_words = {pending_words, w};
   endtask

   task automatic queue_random(int count);
      repeat (count) queue_word(random_word());
   endtask

   task automatic wait_quiet();
      do begin
         @(posedge clock);
         #1;
      end while (pending_words.size() != 0 || req_valid || word_taken ||
                 grants_due.size() != 0);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         word_taken <= 1'b0;
      end else begin
         word_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) taken_word <= req_data;
         if (!req_valid || !req_stall) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_words.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // model update on the falling edge after the word is taken
   always @(negedge clock) begin
      if (word_taken) apply_word(taken_word);
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         holds_served <= 0;
      end else if (holds_served != holds_asked) begin
         hold_left <= HOLD_CYCLES;
         holds_served <= holds_asked;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= (hold_left != 0) || ($urandom_range(99) < rcv_idle_pct);
         if (rsp_valid && !rsp_stall) begin
            if (grants_due.size() == 0) begin
               errors++;
               if (errors <= 40)
                  $display("%0t: result with none expected, got found=%0d slot=%0d",
                           $time, rsp_data.found, rsp_data.granted_slot);
            end else begin
               want = grants_due.pop_front();
               if (want.found !== rsp_data.found ||
                   want.granted_slot !== rsp_data.granted_slot) begin
                  errors++;
                  if (errors <= 40)
                     $display("%0t: mismatch, expected found=%0d slot=%0d, got found=%0d slot=%0d",
                              $time, want.found, want.granted_slot,
                              rsp_data.found, rsp_data.granted_slot);
               end
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("** priority_weighted_round_robin_picker: FAILED **");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      #1;
      sender_idle_pct = 7;
      rcv_idle_pct = 86;

      // empty table, zero-weight group, extremes, removal
      queue_word(pick_word());
      queue_word(table_write(0, 0, 0, 1));
      queue_word(pick_word());
      queue_word(pick_word());
      queue_word(table_write(15, 65535, 65535, 1));
      queue_word(table_write(0, 0, 0, 0));
      queue_word(pick_word());
      // weighted group with a zero-weight member, run through rounds
      queue_word(table_write(3, 5, 2, 1));
      queue_word(table_write(9, 5, 0, 1));
      queue_word(table_write(12, 5, 1, 1));
      repeat (7) queue_word(pick_word());
      // lower priority value takes over, then leaves
      queue_word(table_write(7, 0, 65535, 1));
      queue_word(pick_word());
      queue_word(table_write(7, 65535, 65535, 0));
      queue_word(pick_word());
      queue_word(table_write(3, 5, 2, 0));
      queue_word(table_write(9, 5, 0, 0));
      queue_word(table_write(12, 5, 1, 0));
      queue_word(pick_word());
      queue_random(270);
      wait_quiet();

      sender_idle_pct = 86;
      rcv_idle_pct = 7;
      queue_random(280);
      wait_quiet();

      // no idling; receiver holds off so the block backs up
      sender_idle_pct = 0;
      rcv_idle_pct = 0;
      holds_asked = holds_asked + 1;
      queue_random(290);
      wait_quiet();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("** priority_weighted_round_robin_picker: PASSED **");
      else
         $display("** priority_weighted_round_robin_picker: FAILED **");
      $finish;
   end

endmodule
